FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the keyword hash classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define KHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("khc assertion failed");
// Next-cycle implication.
`define KHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("khc assertion failed");
`else
`define KHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/khc_pkg.sv
// Types, constants and the keyword lookup of the keyword hash classifier.
package khc_pkg;

	localparam logic [31:0] HASH_TOP_MASK = 32'hF000_0000;

	// Slot width covers the largest supported bucket count.
	localparam int SLOT_W = 10;

	typedef enum logic [3:0] {
		KW_IDENT  = 4'd0,
		KW_NULL   = 4'd1,
		KW_TRUE   = 4'd2,
		KW_FALSE  = 4'd3,
		KW_QUOTE  = 4'd4,
		KW_SETQ   = 4'd5,
		KW_FUNC   = 4'd6,
		KW_LAMBDA = 4'd7,
		KW_PROG   = 4'd8,
		KW_COND   = 4'd9,
		KW_WHILE  = 4'd10,
		KW_RETURN = 4'd11,
		KW_BREAK  = 4'd12
	} kw_code_t;

	localparam logic [SLOT_W-1:0] SLOT_NULL   = 10'd2;
	localparam logic [SLOT_W-1:0] SLOT_TRUE   = 10'd104;
	localparam logic [SLOT_W-1:0] SLOT_FALSE  = 10'd29;
	localparam logic [SLOT_W-1:0] SLOT_QUOTE  = 10'd141;
	localparam logic [SLOT_W-1:0] SLOT_SETQ   = 10'd61;
	localparam logic [SLOT_W-1:0] SLOT_FUNC   = 10'd173;
	localparam logic [SLOT_W-1:0] SLOT_LAMBDA = 10'd147;
	localparam logic [SLOT_W-1:0] SLOT_PROG   = 10'd84;
	localparam logic [SLOT_W-1:0] SLOT_COND   = 10'd65;
	localparam logic [SLOT_W-1:0] SLOT_WHILE  = 10'd1;
	localparam logic [SLOT_W-1:0] SLOT_RETURN = 10'd100;
	localparam logic [SLOT_W-1:0] SLOT_BREAK  = 10'd196;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} khc_in_t;

	typedef struct packed {
		logic [7:0] bucket;
		logic [3:0] keyword;
	} khc_out_t;

	// Keyword code by bucket alone; anything off the table is an identifier.
	function automatic kw_code_t kw_lookup(input logic [SLOT_W-1:0] slot);
		kw_code_t code;
		case (slot)
			SLOT_NULL:   code = KW_NULL;
			SLOT_TRUE:   code = KW_TRUE;
			SLOT_FALSE:  code = KW_FALSE;
			SLOT_QUOTE:  code = KW_QUOTE;
			SLOT_SETQ:   code = KW_SETQ;
			SLOT_FUNC:   code = KW_FUNC;
			SLOT_LAMBDA: code = KW_LAMBDA;
			SLOT_PROG:   code = KW_PROG;
			SLOT_COND:   code = KW_COND;
			SLOT_WHILE:  code = KW_WHILE;
			SLOT_RETURN: code = KW_RETURN;
			SLOT_BREAK:  code = KW_BREAK;
			default:     code = KW_IDENT;
		endcase
		return code;
	endfunction

endpackage

FILE: src/khc_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface khc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/keyword_hash_classifier_unit.sv
// Keyword hash classifier: PJW word hash, bucket modulo and keyword lookup.
// Throughput: one character item per cycle while the result side keeps up.
// Pipeline: the hash of a word's last character is registered in h_s1, then
// passes through the modulo pipeline (two folds, reciprocal multiply,
// correction) to the output register slot_s6; a stalled output holds it back.
// Reset: arst_n clears the running hash and every pipeline valid bit at once.
`include "assert_macros.svh"

module keyword_hash_classifier_unit #(
	parameter int BUCKETS = 211
) (
	input  logic      clk,
	input  logic      arst_n,
	khc_stream_if.sink   chars,
	khc_stream_if.source words
);

	// Remainder width, and the width that holds BUCKETS itself.
	localparam int RW = $clog2(BUCKETS);
	localparam int BW = $clog2(BUCKETS + 1);
	// Folding constant: 2^16 mod BUCKETS.
	localparam int R16_I = 65536 % BUCKETS;
	localparam logic [RW-1:0] R16 = RW'(R16_I);
	// Reciprocal floor(2^32 / BUCKETS); quotient estimate is short by at most one.
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
	localparam logic [BW-1:0] B_C = BW'(BUCKETS);
	localparam logic [RW:0] B_R = (RW + 1)'(BUCKETS);
	// Widths of the folded value after the first and second fold.
	localparam int X2W = 17 + RW;
	localparam int X3W = ((2 * RW + 1 > 16) ? 2 * RW + 1 : 16) + 1;

	// Running hash of the current word.
	logic [31:0] hash_q;
	logic [31:0] hash_next;
	logic [31:0] hash_sum;
	logic [31:0] hash_top;
	logic        acc;

	// Stage valids and per-stage advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	// Stage payloads.
	logic [31:0]         h_s1;
	logic [X2W-1:0]      x_s2;
	logic [X3W-1:0]      x_s3;
	logic [X3W-1:0]      x_s4;
	logic [X3W-1:0]      q_s4;
	logic [RW:0]         r_s5;
	logic [khc_pkg::SLOT_W-1:0] slot_s6;
	logic [3:0]          keyword_s6;

	// Combinational stage logic.
	logic [16+RW-1:0]    p2;
	logic [X2W-1:0]      x2;
	logic [2*RW:0]       p3;
	logic [X3W-1:0]      x3;
	logic [X3W+31:0]     p4;
	logic [X3W+BW-1:0]   p5;
	logic [X3W-1:0]      d5;
	logic [RW:0]         rem6;
	logic [khc_pkg::SLOT_W-1:0] slot6;

	// Backpressure: a stage takes new data when it is empty or moving on.
	assign rdy6 = !v_s6 || words.ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign chars.ready = rdy1;
	assign acc         = chars.valid && chars.ready;

	// PJW update: shift in the byte, fold the top nibble back in, clear it.
	always_comb begin
		hash_sum  = (hash_q << 4) + {24'd0, chars.data.ch};
		hash_top  = hash_sum & khc_pkg::HASH_TOP_MASK;
		hash_next = (hash_sum ^ (hash_top >> 24)) ^ hash_top;
	end

	// Stage 2: fold the upper half down using 2^16 mod BUCKETS.
	always_comb begin
		p2 = h_s1[31:16] * R16;
		x2 = X2W'(p2) + X2W'(h_s1[15:0]);
	end

	// Stage 3: fold once more so the value is short enough for the reciprocal.
	always_comb begin
		p3 = x_s2[X2W-1:16] * R16;
		x3 = X3W'(p3) + X3W'(x_s2[15:0]);
	end

	// Stage 4: quotient estimate from the reciprocal.
	assign p4 = x_s3 * RECIP;

	// Stage 5: partial remainder, below twice the bucket count.
	always_comb begin
		p5 = q_s4 * B_C;
		d5 = x_s4 - X3W'(p5);
	end

	// Stage 6: final correction, then keyword lookup on the full remainder.
	always_comb begin
		rem6  = (r_s5 >= B_R) ? (r_s5 - B_R) : r_s5;
		slot6 = khc_pkg::SLOT_W'(rem6);
	end

	// Control state: hash accumulator and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
		end else begin
			// Clear the hash after the last character of a word.
			if (acc) begin
				hash_q <= chars.data.last ? 32'd0 : hash_next;
			end
			if (rdy1) begin
				v_s1 <= acc && chars.data.last;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
			if (rdy6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Payload registers: advance only with valid data behind them.
	always_ff @(posedge clk) begin
		if (rdy1 && acc && chars.data.last) begin
			h_s1 <= hash_next;
		end
		if (rdy2 && v_s1) begin
			x_s2 <= x2;
		end
		if (rdy3 && v_s2) begin
			x_s3 <= x3;
		end
		if (rdy4 && v_s3) begin
			q_s4 <= p4[X3W+31:32];
			x_s4 <= x_s3;
		end
		if (rdy5 && v_s4) begin
			r_s5 <= d5[RW:0];
		end
		if (rdy6 && v_s5) begin
			slot_s6    <= slot6;
			keyword_s6 <= khc_pkg::kw_lookup(slot6);
		end
	end

	// Output register drives the result channel directly.
	assign words.valid        = v_s6;
	assign words.data.bucket  = slot_s6[7:0];
	assign words.data.keyword = keyword_s6;

	`KHC_ASSERT_NEXT(a_hash_cleared, clk, arst_n, acc && chars.data.last, hash_q == 32'd0)
	`KHC_ASSERT_NEXT(a_word_enters, clk, arst_n, acc && chars.data.last, v_s1)
	`KHC_ASSERT_IMPL(a_partial_rem, clk, arst_n, v_s5, r_s5 < (B_R << 1))
	`KHC_ASSERT_IMPL(a_final_rem, clk, arst_n, v_s6, slot_s6 < khc_pkg::SLOT_W'(BUCKETS))

endmodule
